// ===== rtl/core/ktiat_pkg.sv =====
// ----------------------------------------------------------------------------
// ktiat_pkg
// Shared types and constants for the key to index assignment table: payload
// words, request modes, controller states and controller/datapath signals.
// ----------------------------------------------------------------------------
package ktiat_pkg;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned TOTAL_W = 7;

  // Request modes
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_FIND   = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;

  typedef struct packed {
    logic [1:0]       mode;
    logic [KEY_W-1:0] key_high;
    logic [KEY_W-1:0] key_low;
    logic [POS_W-1:0] position;
  } in_word_t;

  typedef struct packed {
    logic               found;
    logic               inserted;
    logic               table_full;
    logic [SLOT_W-1:0]  slot;
    logic [KEY_W-1:0]   out_key_high;
    logic [KEY_W-1:0]   out_key_low;
    logic [TOTAL_W-1:0] entry_total;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_FINISH
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic start;   // capture the request word, rewind the scan
    logic scan;    // issue the next table read and compare the previous one
    logic rd_pos;  // read the entry at the requested position
    logic finish;  // build the result, load the output register, commit inserts
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;  // key matched or all held entries compared
    logic out_free;   // output register can take a result this cycle
  } sts_t;

endpackage

// ===== rtl/core/ktiat_ctrl.sv =====
// ----------------------------------------------------------------------------
// ktiat_ctrl
// Sequencer for the table: accepts a word, steps the scan or the indexed read
// (neither for an unused mode), then hands the result to the output register.
// ----------------------------------------------------------------------------
module ktiat_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [1:0]      in_mode_i,
  output logic            in_ready_o,
  input  ktiat_pkg::sts_t sts_i,
  output ktiat_pkg::cmd_t cmd_o
);

  ktiat_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ktiat_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ktiat_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          unique case (in_mode_i) inside
            ktiat_pkg::MODE_INSERT, ktiat_pkg::MODE_FIND: state_d = ktiat_pkg::ST_SCAN;
            ktiat_pkg::MODE_READ:                         state_d = ktiat_pkg::ST_READ;
            default:                                      state_d = ktiat_pkg::ST_FINISH;
          endcase
        end
      end
      ktiat_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ktiat_pkg::ST_FINISH;
        end
      end
      ktiat_pkg::ST_READ: begin
        cmd_o.rd_pos = 1'b1;
        state_d      = ktiat_pkg::ST_FINISH;
      end
      ktiat_pkg::ST_FINISH: begin
        // hold until the output register is free
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ktiat_pkg::ST_IDLE;
        end
      end
      default: state_d = ktiat_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/ktiat_dpath.sv =====
// ----------------------------------------------------------------------------
// ktiat_dpath
// Key store memory, entry count, sequential key compare and the output
// register of the table.
// ----------------------------------------------------------------------------
module ktiat_dpath #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ktiat_pkg::cmd_t      cmd_i,
  output ktiat_pkg::sts_t      sts_o,
  input  ktiat_pkg::in_word_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ktiat_pkg::out_word_t out_data_o
);

  localparam int unsigned IdxW   = $clog2(ENTRIES);
  localparam int unsigned CntW   = $clog2(ENTRIES + 1);
  localparam int unsigned KeyW   = ktiat_pkg::KEY_W;
  localparam int unsigned SlotW  = ktiat_pkg::SLOT_W;
  localparam int unsigned TotalW = ktiat_pkg::TOTAL_W;

  // Key store, written only at the fill point, never cleared
  logic [KeyW-1:0] upper_mem [ENTRIES];
  logic [KeyW-1:0] lower_mem [ENTRIES];

  ktiat_pkg::in_word_t  req_q;
  ktiat_pkg::out_word_t out_q, res_d;
  logic                 out_valid_q, out_valid_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [CntW-1:0]      issue_q;
  logic                 pend_q;
  logic [IdxW-1:0]      pend_idx_q;
  logic                 hit_q;
  logic [IdxW-1:0]      hit_idx_q;
  logic [KeyW-1:0]      rd_hi_q, rd_lo_q;

  logic            issue_more;
  logic            match;
  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  logic            wr_en;
  logic            pos_ok;
  logic            is_full;

  assign issue_more = issue_q < cnt_q;
  assign match      = pend_q && (rd_hi_q == req_q.key_high) && (rd_lo_q == req_q.key_low);
  assign rd_en      = (cmd_i.scan && issue_more) || cmd_i.rd_pos;
  assign rd_addr    = cmd_i.rd_pos ? IdxW'(req_q.position) : issue_q[IdxW-1:0];
  assign pos_ok     = 32'(req_q.position) < 32'(cnt_q);
  assign is_full    = cnt_q == CntW'(ENTRIES);

  assign sts_o.scan_done = match || !issue_more;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // Result of the finished request and the count after it
  always_comb begin
    res_d = '0;
    cnt_d = cnt_q;
    wr_en = 1'b0;
    case (req_q.mode)
      ktiat_pkg::MODE_INSERT: begin
        if (hit_q) begin
          res_d.found = 1'b1;
          res_d.slot  = SlotW'(hit_idx_q);
        end else if (is_full) begin
          res_d.table_full = 1'b1;
        end else begin
          wr_en          = cmd_i.finish;
          res_d.found    = 1'b1;
          res_d.inserted = 1'b1;
          res_d.slot     = SlotW'(cnt_q);
          cnt_d          = cnt_q + CntW'(1);
        end
      end
      ktiat_pkg::MODE_FIND: begin
        if (hit_q) begin
          res_d.found = 1'b1;
          res_d.slot  = SlotW'(hit_idx_q);
        end
      end
      ktiat_pkg::MODE_READ: begin
        if (pos_ok) begin
          res_d.found        = 1'b1;
          res_d.out_key_high = rd_hi_q;
          res_d.out_key_low  = rd_lo_q;
        end
      end
      default: ;
    endcase
    res_d.entry_total = TotalW'(cnt_d);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      issue_q     <= '0;
      pend_q      <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cmd_i.finish) begin
        cnt_q <= cnt_d;
      end
      if (cmd_i.start) begin
        issue_q <= '0;
        pend_q  <= 1'b0;
        hit_q   <= 1'b0;
      end else if (cmd_i.scan) begin
        issue_q <= issue_q + CntW'(issue_more);
        pend_q  <= issue_more;
        if (match) begin
          hit_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      req_q <= in_data_i;
    end
    if (cmd_i.scan) begin
      pend_idx_q <= issue_q[IdxW-1:0];
      if (match) begin
        hit_idx_q <= pend_idx_q;
      end
    end
    if (cmd_i.finish) begin
      out_q <= res_d;
    end
  end

  // Key store ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      upper_mem[cnt_q[IdxW-1:0]] <= req_q.key_high;
      lower_mem[cnt_q[IdxW-1:0]] <= req_q.key_low;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_hi_q <= upper_mem[rd_addr];
      rd_lo_q <= lower_mem[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(ENTRIES))
    else $error("entry count above table size");

  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan |-> issue_q <= cnt_q)
    else $error("scan pointer past entry count");

  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending word");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && res_d.inserted) |=> cnt_q == CntW'($past(cnt_q) + CntW'(1)))
    else $error("insert did not advance the entry count");

endmodule

// ===== rtl/core/key_to_index_assignment_table.sv =====
// ----------------------------------------------------------------------------
// key_to_index_assignment_table
// Table of unique 128-bit keys, each given a dense index in arrival order.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_ready_o / in_data_i) takes one request
//   word: insert-or-get, find, or read-by-position. The output channel
//   (out_valid_o / out_ready_i / out_data_o) returns one result word per
//   request, always carrying the entry count after the request.
// Operation:
//   Keys are held in a memory with one read port and are compared one entry
//   per cycle. An insert or find compares the held keys in index order and
//   stops at a match or after the last held key; a read by position does one
//   indexed read; an unused mode goes straight to the result. The sequential
//   compare over the memory read port sets the cost of each request.
// Reset:
//   Clears the entry count and all control; the key memory is left as is and
//   entries at or above the count are never reported.
// Stalls:
//   A finished result waits in the output register while the next request is
//   accepted and scanned; that request holds in its final step until the
//   receiver takes the waiting word.
// ----------------------------------------------------------------------------
module key_to_index_assignment_table #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ktiat_pkg::in_word_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ktiat_pkg::out_word_t out_data_o
);

  ktiat_pkg::cmd_t cmd;
  ktiat_pkg::sts_t sts;

  // Sequencer: decides scan, indexed read or direct finish per word
  ktiat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_mode_i  (in_data_i.mode),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Key memory, count, compare and output register
  ktiat_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
